FILE: hw/rtl/flk_pkg.sv
// ----------------------------------------------------------------------------
// flk_pkg - shared types and constants for the flocking steering block
// Item and result beat layouts, rule codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package flk_pkg;

  // Rule codes carried in func
  localparam logic [1:0] FUNC_ALIGN = 2'd0;
  localparam logic [1:0] FUNC_COH   = 2'd1;
  localparam logic [1:0] FUNC_SEP   = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W     = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FORCE = 1'b1;
  localparam int unsigned CFG_W         = 31;
  localparam logic [CFG_W-1:0] MAX_SPEED_RST = 31'd262144;
  localparam logic [CFG_W-1:0] MAX_FORCE_RST = 31'd6554;

  // Defaults for top-level parameters
  localparam int unsigned MAX_NEIGHBORS_DEF = 256;
  localparam int unsigned FRAC_BITS_DEF     = 16;
  localparam int unsigned FIFO_DEPTH_DEF    = 2;

  // Shared divider: 64-bit dividend, 32-bit divisor
  localparam int unsigned DIV_W  = 64;
  localparam int unsigned DIVR_W = 32;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] own_px;
    logic signed [31:0] own_py;
    logic signed [31:0] own_pz;
    logic signed [31:0] own_vx;
    logic signed [31:0] own_vy;
    logic signed [31:0] own_vz;
    logic signed [31:0] nbr_x;
    logic signed [31:0] nbr_y;
    logic signed [31:0] nbr_z;
    logic               last_nbr;
  } flk_in_t;

  typedef struct packed {
    logic signed [31:0] steer_x;
    logic signed [31:0] steer_y;
    logic signed [31:0] steer_z;
  } flk_out_t;

  // Divider request from the sequencer
  typedef struct packed {
    logic              go;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } flk_div_req_t;

endpackage

FILE: hw/rtl/flk_div.sv
// ----------------------------------------------------------------------------
// flk_div - iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
module flk_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  flk_pkg::flk_div_req_t req,
  output logic                  done,
  output logic [flk_pkg::DIV_W-1:0] quotient
);
  import flk_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIV_W);

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   step_r;
  logic [DIVR_W-1:0]   dvs_r;
  logic [DIVR_W-1:0]   rem_r;
  logic [DIV_W-1:0]    quo_r;
  logic [DIVR_W:0]     rem_sh;
  logic                fits;

  // trial subtract of the shifted remainder
  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DIV_W - 1);
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= fits ? DIVR_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DIVR_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], fits};
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/flk_fifo.sv
// ----------------------------------------------------------------------------
// flk_fifo - short item queue between front and back
// Register-based FIFO with valid/ready on both sides.
// ----------------------------------------------------------------------------
module flk_fifo #(
  parameter int unsigned DEPTH = flk_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  flk_pkg::flk_in_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output flk_pkg::flk_in_t pop_data
);
  import flk_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  flk_in_t        mem_r [DEPTH];
  logic [PW-1:0]  wr_r;
  logic [PW-1:0]  rd_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = cnt_r != CW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        mem_r[wr_r] <= push_data;
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/flk_front.sv
// ----------------------------------------------------------------------------
// flk_front - input stage
// Takes item beats, drops beats with the unused rule code, and holds the
// rest in a register until the queue takes them.
// ----------------------------------------------------------------------------
module flk_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  flk_pkg::flk_in_t in_data,
  output logic             push_valid,
  input  logic             push_ready,
  output flk_pkg::flk_in_t push_data
);
  import flk_pkg::*;

  logic    hold_v_r;
  flk_in_t hold_r;

  assign in_ready   = !hold_v_r || push_ready;
  assign push_valid = hold_v_r;
  assign push_data  = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      if (hold_v_r && push_ready) begin
        hold_v_r <= 1'b0;
      end
      // unused rule: beat is consumed without effect
      if (in_valid && in_ready && in_data.func != FUNC_NONE) begin
        hold_v_r <= 1'b1;
        hold_r   <= in_data;
      end
    end
  end

endmodule

FILE: hw/rtl/flk_back.sv
// ----------------------------------------------------------------------------
// flk_back - steering sequencer
// Sums neighbor contributions; on the closing item it averages, subtracts own
// position for cohesion, rescales, subtracts own velocity, limits force, emits.
// ----------------------------------------------------------------------------
module flk_back #(
  parameter int unsigned MAX_NEIGHBORS = flk_pkg::MAX_NEIGHBORS_DEF,
  parameter int unsigned FRAC_BITS     = flk_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  flk_pkg::flk_in_t          pop_data,
  input  logic [flk_pkg::CFG_W-1:0] max_speed,
  input  logic [flk_pkg::CFG_W-1:0] max_force,
  output logic                      out_valid,
  input  logic                      out_ready,
  output flk_pkg::flk_out_t         out_data
);
  import flk_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned SUM_W = 33 + CNT_W;
  localparam int unsigned VEC_W = SUM_W + 1;
  localparam int unsigned SH_W  = $clog2(VEC_W);

  typedef enum logic [4:0] {
    S_IDLE, S_FINAL, S_AVG_ST, S_AVG_W, S_COH, S_MAGLD, S_NORM, S_SQ, S_SQA,
    S_SQRT, S_BRANCH, S_SDIV_ST, S_SDIV_W, S_MUL, S_RDIV_ST, S_RDIV_W,
    S_SUBV, S_OUT
  } state_t;

  typedef enum logic [1:0] {PH_SEP, PH_RS1, PH_CHK, PH_RS2} phase_t;

  state_t                   state_r;
  phase_t                   phase_r;
  flk_in_t                  ent_r;
  logic signed [SUM_W-1:0]  sum_r [3];
  logic [CNT_W-1:0]         cnt_r;
  logic signed [VEC_W-1:0]  vec_r [3];
  logic [VEC_W-1:0]         mag_r [3];
  logic                     neg_r [3];
  logic [SH_W-1:0]          sh_r;
  logic [1:0]               idx_r;
  logic [61:0]              prod_r;
  logic [63:0]              acc_r;
  logic [63:0]              sq_v_r;
  logic [63:0]              sq_r;
  logic [4:0]               k_r;
  logic [31:0]              len_r;
  logic [CFG_W-1:0]         target_r;
  flk_div_req_t             div_req_r;
  logic                     out_valid_r;
  flk_out_t                 out_r;

  logic                     div_done;
  logic [DIV_W-1:0]         div_quo;

  logic signed [VEC_W-1:0]  own_p [3];
  logic signed [VEC_W-1:0]  own_v [3];
  logic signed [VEC_W-1:0]  in_p  [3];
  logic signed [VEC_W-1:0]  in_n  [3];
  logic signed [SUM_W-1:0]  in_ns [3];
  logic [VEC_W-1:0]         vec_abs [3];
  logic [SUM_W-1:0]         sum_abs [3];
  logic [31:0]              steer [3];
  logic                     too_big;
  logic [63:0]              sq_b;
  logic [63:0]              sq_t;
  logic                     sq_ge;
  logic [63:0]              sq_r_nxt;
  logic [VEC_W-1:0]         q_rs;
  logic [VEC_W-1:0]         q_avg;
  logic [SUM_W-1:0]         q_sep;
  logic [63:0]              len_sh;

  flk_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sign-extended operands
  always_comb begin
    own_p[0] = {{(VEC_W-32){ent_r.own_px[31]}}, ent_r.own_px};
    own_p[1] = {{(VEC_W-32){ent_r.own_py[31]}}, ent_r.own_py};
    own_p[2] = {{(VEC_W-32){ent_r.own_pz[31]}}, ent_r.own_pz};
    own_v[0] = {{(VEC_W-32){ent_r.own_vx[31]}}, ent_r.own_vx};
    own_v[1] = {{(VEC_W-32){ent_r.own_vy[31]}}, ent_r.own_vy};
    own_v[2] = {{(VEC_W-32){ent_r.own_vz[31]}}, ent_r.own_vz};
    in_p[0]  = {{(VEC_W-32){pop_data.own_px[31]}}, pop_data.own_px};
    in_p[1]  = {{(VEC_W-32){pop_data.own_py[31]}}, pop_data.own_py};
    in_p[2]  = {{(VEC_W-32){pop_data.own_pz[31]}}, pop_data.own_pz};
    in_n[0]  = {{(VEC_W-32){pop_data.nbr_x[31]}}, pop_data.nbr_x};
    in_n[1]  = {{(VEC_W-32){pop_data.nbr_y[31]}}, pop_data.nbr_y};
    in_n[2]  = {{(VEC_W-32){pop_data.nbr_z[31]}}, pop_data.nbr_z};
    for (int i = 0; i < 3; i++) begin
      in_ns[i]   = in_n[i][SUM_W-1:0];
      vec_abs[i] = vec_r[i][VEC_W-1] ? VEC_W'(-vec_r[i]) : VEC_W'(vec_r[i]);
      sum_abs[i] = sum_r[i][SUM_W-1] ? SUM_W'(-sum_r[i]) : SUM_W'(sum_r[i]);
      // saturate to signed 32 bits
      if (vec_r[i][VEC_W-1:31] == '0 || vec_r[i][VEC_W-1:31] == '1) begin
        steer[i] = vec_r[i][31:0];
      end else begin
        steer[i] = vec_r[i][VEC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
    end
  end

  // one step of the bitwise square root
  assign sq_b     = 64'd1 << {k_r, 1'b0};
  assign sq_t     = sq_r + sq_b;
  assign sq_ge    = sq_v_r >= sq_t;
  assign sq_r_nxt = sq_ge ? (sq_r >> 1) + sq_b : sq_r >> 1;

  assign q_rs    = VEC_W'(div_quo[31:0]);
  assign q_avg   = VEC_W'(div_quo[SUM_W-1:0]);
  assign q_sep   = SUM_W'(div_quo[FRAC_BITS:0]);
  assign len_sh  = {32'd0, len_r} << sh_r;
  assign too_big = len_sh > {33'd0, max_force};

  assign pop_ready = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_SEP;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      div_req_r.go <= 1'b0;
      idx_r        <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      div_req_r.go <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            ent_r <= pop_data;
            if (cnt_r < CNT_W'(MAX_NEIGHBORS)) begin
              cnt_r <= cnt_r + 1'b1;
              if (pop_data.func == FUNC_SEP) begin
                for (int i = 0; i < 3; i++) begin
                  vec_r[i] <= in_p[i] - in_n[i];
                end
                phase_r <= PH_SEP;
                state_r <= S_MAGLD;
              end else begin
                for (int i = 0; i < 3; i++) begin
                  sum_r[i] <= sum_r[i] + in_ns[i];
                end
                state_r <= pop_data.last_nbr ? S_FINAL : S_IDLE;
              end
            end else begin
              state_r <= pop_data.last_nbr ? S_FINAL : S_IDLE;
            end
          end
        end
        // closing item: average when more than one neighbor
        S_FINAL: begin
          idx_r <= '0;
          if (cnt_r > CNT_W'(1)) begin
            state_r <= S_AVG_ST;
          end else begin
            for (int i = 0; i < 3; i++) begin
              vec_r[i] <= VEC_W'(sum_r[i]);
            end
            state_r <= S_COH;
          end
        end
        S_AVG_ST: begin
          div_req_r.go       <= 1'b1;
          div_req_r.dividend <= DIV_W'(sum_abs[idx_r]);
          div_req_r.divisor  <= DIVR_W'(cnt_r);
          state_r            <= S_AVG_W;
        end
        S_AVG_W: begin
          if (div_done) begin
            vec_r[idx_r] <= sum_r[idx_r][SUM_W-1] ? VEC_W'(-q_avg) : q_avg;
            if (idx_r == 2'd2) begin
              state_r <= S_COH;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_AVG_ST;
            end
          end
        end
        S_COH: begin
          if (ent_r.func == FUNC_COH) begin
            for (int i = 0; i < 3; i++) begin
              vec_r[i] <= vec_r[i] - own_p[i];
            end
          end
          phase_r  <= PH_RS1;
          target_r <= max_speed;
          state_r  <= S_MAGLD;
        end
        // vector length: magnitudes, shift into 31 bits, squares, root
        S_MAGLD: begin
          for (int i = 0; i < 3; i++) begin
            mag_r[i] <= vec_abs[i];
            neg_r[i] <= vec_r[i][VEC_W-1];
          end
          sh_r    <= '0;
          state_r <= S_NORM;
        end
        S_NORM: begin
          if (mag_r[0][VEC_W-1:31] != '0 || mag_r[1][VEC_W-1:31] != '0 ||
              mag_r[2][VEC_W-1:31] != '0) begin
            for (int i = 0; i < 3; i++) begin
              mag_r[i] <= mag_r[i] >> 1;
            end
            sh_r <= sh_r + 1'b1;
          end else begin
            acc_r   <= '0;
            idx_r   <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          prod_r  <= mag_r[idx_r][30:0] * mag_r[idx_r][30:0];
          state_r <= S_SQA;
        end
        S_SQA: begin
          if (idx_r == 2'd2) begin
            sq_v_r  <= acc_r + 64'(prod_r);
            sq_r    <= '0;
            k_r     <= 5'd31;
            state_r <= S_SQRT;
          end else begin
            acc_r   <= acc_r + 64'(prod_r);
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SQ;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_v_r <= sq_v_r - sq_t;
          end
          sq_r <= sq_r_nxt;
          if (k_r == '0) begin
            len_r   <= sq_r_nxt[31:0];
            state_r <= S_BRANCH;
          end else begin
            k_r <= k_r - 1'b1;
          end
        end
        S_BRANCH: begin
          idx_r <= '0;
          case (phase_r)
            PH_SEP: begin
              // zero distance adds nothing
              if (len_r == '0) begin
                state_r <= ent_r.last_nbr ? S_FINAL : S_IDLE;
              end else begin
                state_r <= S_SDIV_ST;
              end
            end
            PH_RS1: begin
              state_r <= (len_r == '0) ? S_SUBV : S_MUL;
            end
            PH_CHK: begin
              if (too_big) begin
                phase_r  <= PH_RS2;
                target_r <= max_force;
                state_r  <= S_MUL;
              end else begin
                state_r <= S_OUT;
              end
            end
            default: begin
              state_r <= S_OUT;
            end
          endcase
        end
        // separation: unit vector into the sums
        S_SDIV_ST: begin
          div_req_r.go       <= 1'b1;
          div_req_r.dividend <= DIV_W'(mag_r[idx_r][30:0]) << FRAC_BITS;
          div_req_r.divisor  <= len_r;
          state_r            <= S_SDIV_W;
        end
        S_SDIV_W: begin
          if (div_done) begin
            sum_r[idx_r] <= neg_r[idx_r] ? sum_r[idx_r] - q_sep : sum_r[idx_r] + q_sep;
            if (idx_r == 2'd2) begin
              state_r <= ent_r.last_nbr ? S_FINAL : S_IDLE;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_SDIV_ST;
            end
          end
        end
        // rescale to target: m * target / len
        S_MUL: begin
          prod_r  <= mag_r[idx_r][30:0] * target_r;
          state_r <= S_RDIV_ST;
        end
        S_RDIV_ST: begin
          div_req_r.go       <= 1'b1;
          div_req_r.dividend <= DIV_W'(prod_r);
          div_req_r.divisor  <= len_r;
          state_r            <= S_RDIV_W;
        end
        S_RDIV_W: begin
          if (div_done) begin
            vec_r[idx_r] <= neg_r[idx_r] ? VEC_W'(-q_rs) : q_rs;
            if (idx_r == 2'd2) begin
              state_r <= (phase_r == PH_RS1) ? S_SUBV : S_OUT;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_MUL;
            end
          end
        end
        S_SUBV: begin
          for (int i = 0; i < 3; i++) begin
            vec_r[i] <= vec_r[i] - own_v[i];
          end
          phase_r <= PH_CHK;
          state_r <= S_MAGLD;
        end
        // result beat once the output register is free
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_r.steer_x <= steer[0];
            out_r.steer_y <= steer[1];
            out_r.steer_z <= steer[2];
            cnt_r         <= '0;
            for (int i = 0; i < 3; i++) begin
              sum_r[i] <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/flocking_steering_rules.sv
// ----------------------------------------------------------------------------
// flocking_steering_rules - boids steering rule engine
// Alignment, cohesion or separation over a streamed neighbor list, Q15.16.
//
//   channel | ports                              | beat
//   --------+------------------------------------+---------------------------
//   input   | in_valid, in_ready, in_data        | one neighbor + own state
//   result  | out_valid, out_ready, out_data     | steering increment
//   config  | cfg_we, cfg_index, cfg_data        | max_speed / max_force
//
// Alignment and cohesion items are summed in the sequencer's idle state. A
// separation item runs one 32-step square root and three passes of the
// shared 64-step divider. A closing item adds three divides for the average
// of more than one neighbor, two length computations and up to two rescales
// of three divides each. Reset is synchronous and needs no clearing pass. A
// two-entry queue lets the input side keep accepting while the sequencer or
// the output stalls.
// ----------------------------------------------------------------------------
module flocking_steering_rules #(
  parameter int unsigned MAX_NEIGHBORS = flk_pkg::MAX_NEIGHBORS_DEF,
  parameter int unsigned FRAC_BITS     = flk_pkg::FRAC_BITS_DEF,
  parameter int unsigned FIFO_DEPTH    = flk_pkg::FIFO_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  flk_pkg::flk_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output flk_pkg::flk_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [flk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [flk_pkg::CFG_W-1:0]     cfg_data
);
  import flk_pkg::*;

  logic [CFG_W-1:0] max_speed_r;
  logic [CFG_W-1:0] max_force_r;
  logic             push_valid;
  logic             push_ready;
  flk_in_t          push_data;
  logic             pop_valid;
  logic             pop_ready;
  flk_in_t          pop_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= MAX_SPEED_RST;
      max_force_r <= MAX_FORCE_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_MAX_SPEED) begin
        max_speed_r <= cfg_data;
      end
      if (cfg_index == REG_MAX_FORCE) begin
        max_force_r <= cfg_data;
      end
    end
  end

  flk_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  flk_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  flk_back #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .FRAC_BITS     (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .max_speed (max_speed_r),
    .max_force (max_force_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
